@@ hdl/kcs_pkg.sv @@
// Shared types and constants for the keyframe channel sampler.
`default_nettype none
package kcs_pkg;

  localparam int unsigned VAL_W       = 16;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CHF_W       = 9;
  localparam int unsigned SLOT_W      = 5;
  localparam int unsigned CFG_W       = 6;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned LANES       = 4;
  localparam int unsigned IN_TDATA_W  = 112;
  localparam int unsigned OUT_TDATA_W = 80;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SAT  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SPAN = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_RD_LO,
    ST_RD_HI,
    ST_CAP_HI,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_item;
    logic wr_key;
    logic scan_rd;
    logic scan_next;
    logic scan_stop;
    logic rd_lo;
    logic cap_lo;
    logic cap_hi;
    logic mul;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_sample;
    logic scan_hit;
    logic scan_last;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

@@ hdl/keyframe_channel_sampler_unit.sv @@
// Keyframe channel sampler: per-channel key tables, linear interpolation.
// Load: each item is accepted, then written to the key RAMs.
// Sample: a linear key scan over S keys (S = 1..keys_in_use-1, one RAM read per key),
// followed by the 51-step bit-serial divider lanes.
// A finished result waits in the output register while the next item is taken.
// Reset (async, active low) idles the controller and sets keys_in_use to 32;
// key stores are not cleared.
`default_nettype none
module keyframe_channel_sampler_unit
  import kcs_pkg::*;
#(
  parameter int unsigned CHANNEL_COUNT = 512,
  parameter int unsigned KEY_DEPTH     = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // channel[8:0], key_slot[13:9], time_value[45:14], in_x, in_y, in_z, in_w [109:46]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // action
  input  wire logic                   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // out_channel[8:0], out_x, out_y, out_z, out_w [72:9], status[74:73]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_W-1:0]       cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  kcs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .in_ready_o(s_axis_tready)
  );

  kcs_dp #(
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .KEY_DEPTH    (KEY_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_valid_i (s_axis_tvalid),
    .in_action_i(s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule
`default_nettype wire

@@ hdl/kcs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kcs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ hdl/kcs_div.sv @@
// One lane of rounded signed division, one quotient bit per cycle.
`default_nettype none
module kcs_div
  import kcs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [49:0] num_i,
  input  wire logic signed [32:0] den_i,
  output logic                    busy_o,
  output logic                    neg_o,
  output logic             [50:0] quot_o
);

  localparam int unsigned NB = 51;

  logic [49:0] up;
  logic [32:0] ud;
  logic [33:0] dd_d, dd_q;
  logic [50:0] sh_d, sh_q;
  logic [33:0] rem_d, rem_q;
  logic [34:0] rem_t;
  logic [5:0]  cnt_d, cnt_q;
  logic        busy_d, busy_q;
  logic        neg_d, neg_q;

  assign up = num_i[49] ? 50'(-num_i) : 50'(num_i);
  assign ud = den_i[32] ? 33'(-den_i) : 33'(den_i);
  assign rem_t = {rem_q, sh_q[NB-1]};

  always_comb begin
    sh_d   = sh_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    dd_d   = dd_q;
    if (start_i) begin
      // round to nearest: (2|p| + |d|) / (2|d|)
      sh_d   = {up, 1'b0} + 51'(ud);
      dd_d   = {ud, 1'b0};
      rem_d  = '0;
      cnt_d  = 6'(NB);
      busy_d = 1'b1;
      neg_d  = num_i[49] ^ den_i[32];
    end else if (busy_q) begin
      if (rem_t >= 35'(dd_q)) begin
        rem_d = 34'(rem_t - 35'(dd_q));
        sh_d  = {sh_q[NB-2:0], 1'b1};
      end else begin
        rem_d = rem_t[33:0];
        sh_d  = {sh_q[NB-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    dd_q  <= dd_d;
  end

  assign busy_o = busy_q;
  assign neg_o  = neg_q;
  assign quot_o = sh_q;

endmodule
`default_nettype wire

@@ hdl/kcs_dp.sv @@
// Datapath: item registers, key stores, scan, products, dividers, result register.
`default_nettype none
module kcs_dp
  import kcs_pkg::*;
#(
  parameter int unsigned CHANNEL_COUNT = 512,
  parameter int unsigned KEY_DEPTH     = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cmd_t                   cmd_i,
  output stat_t                       stat_o,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_action_i,
  input  wire logic [IN_TDATA_W-1:0]  in_data_i,
  input  wire logic                   cfg_valid_i,
  input  wire logic [CFG_W-1:0]       cfg_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0]      out_data_o
);

  localparam int unsigned DEPTH = CHANNEL_COUNT * KEY_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned KW    = $clog2(KEY_DEPTH + 1);

  logic [CHF_W-1:0]  chf_q;
  logic [CHF_W-1:0]  chm;
  logic [SLOT_W-1:0] slot_q;
  logic [TIME_W-1:0] tv_q;
  logic [4*VAL_W-1:0] kv_q;
  logic [CFG_W-1:0]  kin_q;
  logic [KW-1:0]     n_eff, idx_q, hi_q;
  logic [AW-1:0]     base, rd_addr, wr_addr;
  logic [TIME_W-1:0] t_rdata, tlo_q;
  logic [4*VAL_W-1:0] v_rdata, vlo_q;
  logic signed [32:0] span_q, num_q;
  logic signed [16:0] vdif_q [LANES];
  logic signed [49:0] prod_q [LANES];
  logic              busy [LANES];
  logic              neg  [LANES];
  logic [50:0]       quot [LANES];
  logic              ovalid_q;
  logic [OUT_TDATA_W-1:0] odata_q;
  logic [OUT_TDATA_W-1:0] odata_d;

  // channel modulo CHANNEL_COUNT by restoring steps
  always_comb begin
    logic [21:0] r;
    r = 22'(chf_q);
    for (int k = CHF_W - 1; k >= 0; k--) begin
      if (r >= (22'(CHANNEL_COUNT) << k)) begin
        r = r - (22'(CHANNEL_COUNT) << k);
      end
    end
    chm = r[CHF_W-1:0];
  end

  always_comb begin
    if (kin_q < 6'd2) begin
      n_eff = KW'(2);
    end else if (32'(kin_q) > 32'(KEY_DEPTH)) begin
      n_eff = KW'(KEY_DEPTH);
    end else begin
      n_eff = KW'(kin_q);
    end
  end

  assign base    = AW'(chm) * AW'(KEY_DEPTH);
  assign wr_addr = base + AW'(slot_q);
  always_comb begin
    if (cmd_i.scan_rd) begin
      rd_addr = base + AW'(idx_q);
    end else if (cmd_i.rd_lo) begin
      rd_addr = base + AW'(hi_q - KW'(1));
    end else begin
      rd_addr = base + AW'(hi_q);
    end
  end

  kcs_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_tram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_key && (32'(slot_q) < 32'(KEY_DEPTH))),
    .waddr_i(wr_addr),
    .wdata_i(tv_q),
    .raddr_i(rd_addr),
    .rdata_o(t_rdata)
  );

  kcs_ram #(.WIDTH(4*VAL_W), .DEPTH(DEPTH)) u_vram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_key && (32'(slot_q) < 32'(KEY_DEPTH))),
    .waddr_i(wr_addr),
    .wdata_i(kv_q),
    .raddr_i(rd_addr),
    .rdata_o(v_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kin_q    <= CFG_W'(32);
      ovalid_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        kin_q <= cfg_data_i;
      end
      if (cmd_i.out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      if (cmd_i.load_item) begin
        idx_q <= '0;
      end else if (cmd_i.scan_next) begin
        idx_q <= idx_q + KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      chf_q  <= in_data_i[8:0];
      slot_q <= in_data_i[13:9];
      tv_q   <= in_data_i[45:14];
      kv_q   <= in_data_i[109:46];
    end
    if (cmd_i.scan_stop) begin
      if (t_rdata > tv_q) begin
        hi_q <= (idx_q == '0) ? KW'(1) : idx_q;
      end else begin
        hi_q <= n_eff - KW'(1);
      end
    end
    if (cmd_i.cap_lo) begin
      tlo_q <= t_rdata;
      vlo_q <= v_rdata;
    end
    if (cmd_i.cap_hi) begin
      span_q <= $signed({1'b0, t_rdata}) - $signed({1'b0, tlo_q});
      num_q  <= $signed({1'b0, tv_q}) - $signed({1'b0, tlo_q});
      for (int c = 0; c < LANES; c++) begin
        vdif_q[c] <= 17'($signed(v_rdata[c*VAL_W +: VAL_W]))
                   - 17'($signed(vlo_q[c*VAL_W +: VAL_W]));
      end
    end
    if (cmd_i.mul) begin
      for (int c = 0; c < LANES; c++) begin
        prod_q[c] <= 50'(vdif_q[c] * num_q);
      end
    end
    odata_q <= cmd_i.out_load ? odata_d : odata_q;
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    kcs_div u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(cmd_i.div_start),
      .num_i  (prod_q[g]),
      .den_i  (span_q),
      .busy_o (busy[g]),
      .neg_o  (neg[g]),
      .quot_o (quot[g])
    );
  end

  always_comb begin
    logic signed [52:0] r;
    logic signed [52:0] qs;
    logic [STAT_W-1:0]  st;
    logic [VAL_W-1:0]   res [LANES];
    st = STAT_OK;
    for (int c = 0; c < LANES; c++) begin
      qs = $signed({2'b00, quot[c]});
      r  = 53'($signed(vlo_q[c*VAL_W +: VAL_W]));
      r  = neg[c] ? r - qs : r + qs;
      if (span_q == '0) begin
        res[c] = vlo_q[c*VAL_W +: VAL_W];
      end else if (r > 53'sd32767) begin
        res[c] = 16'h7fff;
        st     = STAT_SAT;
      end else if (r < -53'sd32768) begin
        res[c] = 16'h8000;
        st     = STAT_SAT;
      end else begin
        res[c] = r[VAL_W-1:0];
      end
    end
    if (span_q == '0) begin
      st = STAT_SPAN;
    end
    odata_d = {5'b0, st, res[3], res[2], res[1], res[0], chf_q};
  end

  assign stat_o.in_valid  = in_valid_i;
  assign stat_o.in_sample = (in_action_i == ACT_SAMPLE);
  assign stat_o.scan_hit  = (t_rdata > tv_q);
  assign stat_o.scan_last = (idx_q == n_eff - KW'(2));
  assign stat_o.div_busy  = busy[0];
  assign stat_o.out_free  = !ovalid_q || out_ready_i;

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

endmodule
`default_nettype wire

@@ hdl/kcs_ctrl.sv @@
// Controller state machine sequencing loads, key scan, divide and result.
`default_nettype none
module kcs_ctrl
  import kcs_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o,
  output logic       in_ready_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (stat_i.in_valid) begin
          state_d = stat_i.in_sample ? ST_SCAN_RD : ST_WRITE;
        end
      end
      ST_WRITE:    state_d = ST_IDLE;
      ST_SCAN_RD:  state_d = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        state_d = (stat_i.scan_hit || stat_i.scan_last) ? ST_RD_LO : ST_SCAN_RD;
      end
      ST_RD_LO:    state_d = ST_RD_HI;
      ST_RD_HI:    state_d = ST_CAP_HI;
      ST_CAP_HI:   state_d = ST_MUL;
      ST_MUL:      state_d = ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (!stat_i.div_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = stat_i.in_valid;
      end
      ST_WRITE:    cmd_o.wr_key = 1'b1;
      ST_SCAN_RD:  cmd_o.scan_rd = 1'b1;
      ST_SCAN_CMP: begin
        if (stat_i.scan_hit || stat_i.scan_last) begin
          cmd_o.scan_stop = 1'b1;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      ST_RD_LO:    cmd_o.rd_lo = 1'b1;
      ST_RD_HI:    cmd_o.cap_lo = 1'b1;
      ST_CAP_HI:   cmd_o.cap_hi = 1'b1;
      ST_MUL:      cmd_o.mul = 1'b1;
      ST_DIV_GO:   cmd_o.div_start = 1'b1;
      ST_DIV_WAIT: cmd_o = '0;
      ST_DONE:     cmd_o.out_load = stat_i.out_free;
      default:     cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire
